// ----- design/lfe_pkg.sv -----
// Shared constants, types and command codes of the lowpass-with-delay block.
package lfe_pkg;

  localparam int MAX_DELAY      = 4096;
  localparam int ADDR_BITS      = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int DLY_BITS       = ADDR_BITS + 1;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_BITS      = 24;
  localparam int COEF_FRAC_BITS = 22;
  localparam int DELAY_BITS     = 13;
  localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS       = PROD_BITS + 3;
  localparam int NUM_TAPS       = 5;
  localparam int TAP_BITS       = 3;
  localparam int APB_ADDR_BITS  = 5;
  localparam int APB_DATA_BITS  = 32;

  typedef enum logic [2:0] {
    REG_FIRST_B0,
    REG_FIRST_A1,
    REG_FIRST_A2,
    REG_SECOND_B0,
    REG_SECOND_A1,
    REG_SECOND_A2,
    REG_DELAY_LENGTH
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_ROUND,
    ST_MEM,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_MAC,
    CMD_ROUND,
    CMD_MEM,
    CMD_OUT
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t             op;
    logic                sec;
    logic [TAP_BITS-1:0] tap;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
  } status_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] b0;
    logic signed [COEF_BITS-1:0] a1;
    logic signed [COEF_BITS-1:0] a2;
  } sec_coef_t;

  typedef struct packed {
    sec_coef_t             first_sec;
    sec_coef_t             second_sec;
    logic [DELAY_BITS-1:0] delay_length;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x1;
    logic signed [SAMPLE_BITS-1:0] x2;
    logic signed [SAMPLE_BITS-1:0] y1;
    logic signed [SAMPLE_BITS-1:0] y2;
  } hist_t;

endpackage

// ----- design/lfe_lowpass_with_delay_unit.sv -----
// Top level of the stereo-to-LFE lowpass filter with a configurable delay line.
// A result is offered once its beat has passed both biquad sections and the delay step.
// The ten products share one multiplier; a beat is taken only when the controller is idle.
// A pending result does not block the next beat until that beat reaches the output stage.
// Reset (synchronous, active high) clears the control state, pointers and filter history,
// then a clearing pass zeroes the delay memory before the first input beat is taken.
module lfe_lowpass_with_delay_unit
  import lfe_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] lfe_sample,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_BITS-1:0]      paddr,
  input  logic [APB_DATA_BITS-1:0]      pwdata,
  output logic [APB_DATA_BITS-1:0]      prdata,
  output logic                          pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  lfe_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lfe_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg          (cfg),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .lfe_sample   (lfe_sample),
    .status       (status)
  );

endmodule

// ----- design/lfe_regs.sv -----
// APB configuration registers for the filter coefficients and the delay length.
module lfe_regs
  import lfe_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg
);

  reg_index_t idx;
  logic       wr_en;

  assign idx    = reg_index_t'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  function automatic logic [APB_DATA_BITS-1:0] sext(input logic [COEF_BITS-1:0] v);
    sext = {{(APB_DATA_BITS-COEF_BITS){v[COEF_BITS-1]}}, v};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (idx)
        REG_FIRST_B0:     cfg.first_sec.b0  <= pwdata[COEF_BITS-1:0];
        REG_FIRST_A1:     cfg.first_sec.a1  <= pwdata[COEF_BITS-1:0];
        REG_FIRST_A2:     cfg.first_sec.a2  <= pwdata[COEF_BITS-1:0];
        REG_SECOND_B0:    cfg.second_sec.b0 <= pwdata[COEF_BITS-1:0];
        REG_SECOND_A1:    cfg.second_sec.a1 <= pwdata[COEF_BITS-1:0];
        REG_SECOND_A2:    cfg.second_sec.a2 <= pwdata[COEF_BITS-1:0];
        REG_DELAY_LENGTH: cfg.delay_length  <= pwdata[DELAY_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FIRST_B0:     prdata = sext(cfg.first_sec.b0);
      REG_FIRST_A1:     prdata = sext(cfg.first_sec.a1);
      REG_FIRST_A2:     prdata = sext(cfg.first_sec.a2);
      REG_SECOND_B0:    prdata = sext(cfg.second_sec.b0);
      REG_SECOND_A1:    prdata = sext(cfg.second_sec.a1);
      REG_SECOND_A2:    prdata = sext(cfg.second_sec.a2);
      REG_DELAY_LENGTH: prdata = {{(APB_DATA_BITS-DELAY_BITS){1'b0}}, cfg.delay_length};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- design/lfe_ctrl.sv -----
// Controller state machine that sequences the clear pass, the shared MAC and the delay line.
module lfe_ctrl
  import lfe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [TAP_BITS-1:0] LAST_TAP = TAP_BITS'(NUM_TAPS);

  state_t              state, state_next;
  logic                sec, sec_next;
  logic [TAP_BITS-1:0] tap, tap_next;
  logic                out_valid_next;
  logic                load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sec       <= 1'b0;
      tap       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      sec       <= sec_next;
      tap       <= tap_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    sec_next   = sec;
    tap_next   = tap;
    load_out   = 1'b0;
    cmd.op     = CMD_IDLE;
    cmd.sec    = sec;
    cmd.tap    = tap;
    case (state)
      ST_CLEAR: begin
        cmd.op = CMD_CLEAR;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = ST_MAC;
          sec_next   = 1'b0;
          tap_next   = '0;
        end
      end
      ST_MAC: begin
        cmd.op = CMD_MAC;
        if (tap == LAST_TAP) state_next = ST_ROUND;
        else tap_next = tap + 1'b1;
      end
      ST_ROUND: begin
        cmd.op = CMD_ROUND;
        if (!sec) begin
          sec_next   = 1'b1;
          tap_next   = '0;
          state_next = ST_MAC;
        end else begin
          state_next = ST_MEM;
        end
      end
      ST_MEM: begin
        cmd.op     = CMD_MEM;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.op     = CMD_OUT;
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
    out_valid_next = load_out | (out_valid & out_stall);
  end

  assign in_stall = (state != ST_IDLE);

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_MAC && tap == '0 && !sec))
    else $error("accepted beat did not start the first section");

  a_no_out_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !out_valid)
    else $error("result offered during the clearing pass");

  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_valid && out_stall) |=> (state == ST_OUT && out_valid))
    else $error("pending result overwritten while stalled");

endmodule

// ----- design/lfe_dp.sv -----
// Datapath: mono mix, shared multiplier and accumulator, biquad histories and delay memory.
module lfe_dp
  import lfe_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  input  cfg_t                          cfg,
  input  logic signed [SAMPLE_BITS-1:0] left_sample,
  input  logic signed [SAMPLE_BITS-1:0] right_sample,
  output logic signed [SAMPLE_BITS-1:0] lfe_sample,
  output status_t                       status
);

  localparam logic signed [ACC_BITS-1:0] ACC_HALF = ACC_BITS'(64'd1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_BITS-1:0] ACC_SMAX = ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] ACC_SMIN = -ACC_SMAX - 1;
  localparam logic [ADDR_BITS-1:0]       LAST_ADDR = ADDR_BITS'(MAX_DELAY - 1);
  localparam logic [DLY_BITS-1:0]        DLY_MAX = DLY_BITS'(MAX_DELAY);

  logic signed [SAMPLE_BITS-1:0] mono;
  logic signed [SAMPLE_BITS:0]   mono_sum;
  hist_t                         hist [2];
  hist_t                         h;
  sec_coef_t                     c;
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic signed [COEF_BITS-1:0]   mul_coef;
  logic signed [SAMPLE_BITS-1:0] mul_samp;
  logic signed [PROD_BITS-1:0]   prod_next, prod;
  logic signed [ACC_BITS-1:0]    prod_ext, acc, acc_rnd, shifted;
  logic signed [SAMPLE_BITS-1:0] y_sat;

  logic [SAMPLE_BITS-1:0] mem [MAX_DELAY];
  logic [SAMPLE_BITS-1:0] rdata;
  logic [ADDR_BITS-1:0]   raddr, waddr, wptr, clr_cnt;
  logic [DLY_BITS-1:0]    dsat, rd_sum;
  logic                   wen;
  logic [SAMPLE_BITS-1:0] wdata;
  logic                   bypass;

  assign mono_sum = {left_sample[SAMPLE_BITS-1], left_sample}
                  + {right_sample[SAMPLE_BITS-1], right_sample} + 1'b1;

  assign h    = hist[cmd.sec];
  assign c    = cmd.sec ? cfg.second_sec : cfg.first_sec;
  assign x_in = cmd.sec ? hist[0].y1 : mono;

  always_comb begin
    case (cmd.tap)
      3'd0: begin
        mul_coef = c.b0;
        mul_samp = x_in;
      end
      3'd1: begin
        mul_coef = c.b0;
        mul_samp = h.x1;
      end
      3'd2: begin
        mul_coef = c.b0;
        mul_samp = h.x2;
      end
      3'd3: begin
        mul_coef = c.a1;
        mul_samp = h.y1;
      end
      3'd4: begin
        mul_coef = c.a2;
        mul_samp = h.y2;
      end
      default: begin
        mul_coef = '0;
        mul_samp = '0;
      end
    endcase
  end

  assign prod_next = mul_coef * mul_samp;
  assign prod_ext  = {{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod};

  assign acc_rnd = acc + ACC_HALF;
  assign shifted = acc_rnd >>> COEF_FRAC_BITS;

  always_comb begin
    if (shifted > ACC_SMAX) y_sat = ACC_SMAX[SAMPLE_BITS-1:0];
    else if (shifted < ACC_SMIN) y_sat = ACC_SMIN[SAMPLE_BITS-1:0];
    else y_sat = shifted[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_LOAD) mono <= mono_sum[SAMPLE_BITS:1];
    if (cmd.op == CMD_MAC) begin
      prod <= prod_next;
      case (cmd.tap)
        3'd0:      acc <= '0;
        3'd1:      acc <= acc + prod_ext;
        3'd2:      acc <= acc + (prod_ext <<< 1);
        3'd3:      acc <= acc + prod_ext;
        default:   acc <= acc - prod_ext;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist[0] <= '0;
      hist[1] <= '0;
    end else if (cmd.op == CMD_ROUND) begin
      hist[cmd.sec].x2 <= h.x1;
      hist[cmd.sec].x1 <= x_in;
      hist[cmd.sec].y2 <= h.y1;
      hist[cmd.sec].y1 <= y_sat;
    end
  end

  assign dsat   = (32'(cfg.delay_length) > 32'(MAX_DELAY)) ? DLY_MAX
                                                           : DLY_BITS'(cfg.delay_length);
  assign rd_sum = {1'b0, wptr} + (DLY_MAX - dsat);
  assign raddr  = (rd_sum >= DLY_MAX) ? ADDR_BITS'(rd_sum - DLY_MAX) : rd_sum[ADDR_BITS-1:0];

  always_comb begin
    wen   = 1'b0;
    waddr = wptr;
    wdata = hist[1].y1;
    if (cmd.op == CMD_CLEAR) begin
      wen   = 1'b1;
      waddr = clr_cnt;
      wdata = '0;
    end else if (cmd.op == CMD_MEM && dsat != '0) begin
      wen = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_MEM) rdata <= mem[raddr];
    if (wen) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr    <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.op == CMD_CLEAR) clr_cnt <= (clr_cnt == LAST_ADDR) ? '0 : clr_cnt + 1'b1;
      if (cmd.op == CMD_MEM && dsat != '0) wptr <= (wptr == LAST_ADDR) ? '0 : wptr + 1'b1;
    end
  end

  assign status.clear_last = (clr_cnt == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_MEM) bypass <= (dsat == '0);
    if (cmd.op == CMD_OUT) lfe_sample <= bypass ? hist[1].y1 : rdata;
  end

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_MAC) |-> (cmd.tap <= TAP_BITS'(NUM_TAPS)))
    else $error("multiply-accumulate step out of range");

  a_bypass_keeps_ptr: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_MEM && dsat == '0) |=> $stable(wptr))
    else $error("write pointer moved while the delay line is bypassed");

endmodule

// ----- test/lfe_lowpass_with_delay_unit_tb.sv -----
// Testbench for the lowpass-with-delay block: a self-checking predictor and directed plus random tests.
module lfe_lowpass_with_delay_unit_tb;
  import lfe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_BEATS = 90;
  localparam int WRAP_BEATS = 16;
  localparam int MAX_IDLE = 16;
  localparam int REPORT_LIMIT = 10;
  localparam logic [APB_ADDR_BITS-1:0] UNMAPPED_ADDR = 5'd28;
  localparam longint SAT_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO = -SAT_HI - 1;
  localparam longint HALF_LSB = longint'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_BITS-1:0] PEAK_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] PEAK_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam int COEF_MAX = 8388607;
  localparam int COEF_MIN = -8388608;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;
  logic                          out_valid;
  logic                          out_stall;
  logic signed [SAMPLE_BITS-1:0] lfe_sample;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [APB_ADDR_BITS-1:0]      paddr;
  logic [APB_DATA_BITS-1:0]      pwdata;
  logic [APB_DATA_BITS-1:0]      prdata;
  logic                          pready;

  lfe_lowpass_with_delay_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .lfe_sample   (lfe_sample),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Predictor state: section coefficients, history, delay store.
  longint                        coef_b0 [2];
  longint                        coef_a1 [2];
  longint                        coef_a2 [2];
  longint                        hist_x1 [2];
  longint                        hist_x2 [2];
  longint                        hist_y1 [2];
  longint                        hist_y2 [2];
  logic [DELAY_BITS-1:0]         delay_reg;
  logic signed [SAMPLE_BITS-1:0] delay_mem [MAX_DELAY];
  logic [ADDR_BITS-1:0]          wr_ptr;

  logic signed [SAMPLE_BITS-1:0] lfe_expected_q [$];
  int                            mismatches;
  int                            idle_cycles = 0;
  bit                            gaps_on;
  bit                            stalls_on;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint biquad_step(int s, longint x);
    longint acc;
    longint y;
    acc = coef_b0[s] * x + 2 * coef_b0[s] * hist_x1[s] + coef_b0[s] * hist_x2[s]
        - coef_a1[s] * hist_y1[s] - coef_a2[s] * hist_y2[s];
    y = (acc + HALF_LSB) >>> COEF_FRAC_BITS;
    if (y > SAT_HI) begin
      y = SAT_HI;
    end else if (y < SAT_LO) begin
      y = SAT_LO;
    end
    hist_x2[s] = hist_x1[s];
    hist_x1[s] = x;
    hist_y2[s] = hist_y1[s];
    hist_y1[s] = y;
    return y;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] predict_lfe(
    logic signed [SAMPLE_BITS-1:0] l,
    logic signed [SAMPLE_BITS-1:0] r
  );
    longint                        y;
    int                            d;
    int                            rd;
    logic signed [SAMPLE_BITS-1:0] res;
    y = (longint'(l) + longint'(r) + 1) >>> 1;
    y = biquad_step(0, y);
    y = biquad_step(1, y);
    d = (int'(delay_reg) > MAX_DELAY) ? MAX_DELAY : int'(delay_reg);
    if (d == 0) begin
      res = SAMPLE_BITS'(y);
    end else begin
      rd = (int'(wr_ptr) + MAX_DELAY - d) % MAX_DELAY;
      res = delay_mem[ADDR_BITS'(rd)];
      delay_mem[wr_ptr] = SAMPLE_BITS'(y);
      wr_ptr = wr_ptr + 1'b1;
    end
    return res;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return PEAK_POS;
      1: return PEAK_NEG;
      2: return SAMPLE_BITS'($urandom_range(0, 1023)) - SAMPLE_BITS'(512);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [APB_ADDR_BITS-1:0] reg_addr(reg_index_t r);
    return {r, 2'b00};
  endfunction

  task automatic write_reg(logic [APB_ADDR_BITS-1:0] addr, int value);
    logic [APB_DATA_BITS-1:0] data;
    data = {8'($urandom), 24'(value)};
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    if (addr[1:0] == 2'b00) begin
      case (addr[4:2])
        REG_FIRST_B0:     coef_b0[0] = longint'($signed(data[COEF_BITS-1:0]));
        REG_FIRST_A1:     coef_a1[0] = longint'($signed(data[COEF_BITS-1:0]));
        REG_FIRST_A2:     coef_a2[0] = longint'($signed(data[COEF_BITS-1:0]));
        REG_SECOND_B0:    coef_b0[1] = longint'($signed(data[COEF_BITS-1:0]));
        REG_SECOND_A1:    coef_a1[1] = longint'($signed(data[COEF_BITS-1:0]));
        REG_SECOND_A2:    coef_a2[1] = longint'($signed(data[COEF_BITS-1:0]));
        REG_DELAY_LENGTH: delay_reg = data[DELAY_BITS-1:0];
        default: begin
        end
      endcase
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_filter(int b0_1, int a1_1, int a2_1, int b0_2, int a1_2, int a2_2);
    write_reg(reg_addr(REG_FIRST_B0), b0_1);
    write_reg(reg_addr(REG_FIRST_A1), a1_1);
    write_reg(reg_addr(REG_FIRST_A2), a2_1);
    write_reg(reg_addr(REG_SECOND_B0), b0_2);
    write_reg(reg_addr(REG_SECOND_A1), a1_2);
    write_reg(reg_addr(REG_SECOND_A2), a2_2);
  endtask

  // A stable lowpass pair with a little jitter so that each phase differs.
  task automatic set_lowpass();
    set_filter(10486 + $urandom_range(0, 2000), -7549747, 3397386,
               41943 + $urandom_range(0, 4000), -6710886, 2684355);
  endtask

  task automatic set_random_filter();
    set_filter($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic set_delay(int d);
    write_reg(reg_addr(REG_DELAY_LENGTH), d);
  endtask

  task automatic send_pair(logic signed [SAMPLE_BITS-1:0] l, logic signed [SAMPLE_BITS-1:0] r);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_IDLE) : 0;
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    left_sample = l;
    right_sample = r;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    lfe_expected_q.push_back(predict_lfe(l, r));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (lfe_expected_q.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic test_reset_state();
    send_pair(PEAK_POS, PEAK_POS);
    send_pair(PEAK_NEG, rand_sample());
    drain();
  endtask

  task automatic test_extreme_samples();
    set_filter(COEF_MAX, 0, 0, 1 << 20, 0, 0);
    send_pair(PEAK_POS, PEAK_POS);
    send_pair(PEAK_NEG, PEAK_NEG);
    send_pair(PEAK_POS, PEAK_NEG);
    send_pair(PEAK_NEG, PEAK_POS);
    send_pair('1, '0);
    send_pair('0, '0);
    drain();
    set_filter(COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN);
    send_pair(PEAK_POS, PEAK_POS);
    send_pair(PEAK_NEG, PEAK_NEG);
    send_pair(SAMPLE_BITS'(1), '0);
    send_pair('0, '0);
    drain();
  endtask

  task automatic test_delay_change();
    set_lowpass();
    set_delay(3);
    repeat (4) send_pair(rand_sample(), rand_sample());
    drain();
    set_delay(1);
    repeat (2) send_pair(rand_sample(), rand_sample());
    drain();
    set_delay(0);
    send_pair(rand_sample(), rand_sample());
    drain();
    set_delay(1);
    send_pair(rand_sample(), rand_sample());
    drain();
  endtask

  task automatic test_delay_clamp();
    set_delay((1 << DELAY_BITS) - 1);
    repeat (2) send_pair(rand_sample(), rand_sample());
    drain();
    set_delay(MAX_DELAY + 1);
    send_pair(rand_sample(), rand_sample());
    drain();
    write_reg(UNMAPPED_ADDR, $urandom);
    send_pair(rand_sample(), rand_sample());
    drain();
  endtask

  task automatic test_store_wrap();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_delay(MAX_DELAY);
    repeat (WRAP_BEATS) send_pair(rand_sample(), rand_sample());
    drain();
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          gaps_on = 1'b1;
          stalls_on = 1'b1;
          set_lowpass();
          set_delay($urandom_range(1, 8));
        end
        1: begin
          gaps_on = 1'b1;
          stalls_on = 1'b1;
          set_random_filter();
          set_delay(0);
        end
        2: begin
          gaps_on = 1'b0;
          stalls_on = 1'b0;
          set_lowpass();
          set_delay($urandom_range(0, (1 << DELAY_BITS) - 1));
        end
        default: begin
          gaps_on = 1'b1;
          stalls_on = 1'b1;
          if ($urandom_range(0, 1) == 0) begin
            set_random_filter();
          end else begin
            set_lowpass();
          end
          write_reg(UNMAPPED_ADDR, $urandom);
          set_delay($urandom_range(0, 64));
        end
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (p == 1 && n == PHASE_BEATS / 2) begin
          drain();
        end
        send_pair(rand_sample(), rand_sample());
      end
      drain();
    end
  endtask

  // Result side: stalls land on offered results, then each beat is checked in order.
  initial begin
    int                            hold;
    logic signed [SAMPLE_BITS-1:0] want;
    out_stall = 1'b0;
    mismatches = 0;
    @(negedge clk);
    forever begin
      hold = stalls_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (hold != 0) begin
        out_stall = 1'b1;
        @(posedge clk);
        while (!out_valid) begin
          @(posedge clk);
        end
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
      end
      @(posedge clk);
      while (!out_valid) begin
        @(posedge clk);
      end
      if (lfe_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("Unexpected result beat: lfe_sample %0d", lfe_sample);
        end
      end else begin
        want = lfe_expected_q.pop_front();
        if (lfe_sample !== want) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("Mismatch on lfe_sample: expected %0d, actual %0d", want, lfe_sample);
          end
        end
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    left_sample = '0;
    right_sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    for (int s = 0; s < 2; s++) begin
      coef_b0[s] = 0;
      coef_a1[s] = 0;
      coef_a2[s] = 0;
      hist_x1[s] = 0;
      hist_x2[s] = 0;
      hist_y1[s] = 0;
      hist_y2[s] = 0;
    end
    delay_reg = '0;
    wr_ptr = '0;
    for (int i = 0; i < MAX_DELAY; i++) begin
      delay_mem[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_extreme_samples();
    test_delay_change();
    test_delay_clamp();
    test_store_wrap();
    test_random_traffic();

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && lfe_expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lfe_pkg.sv
design/lfe_regs.sv
design/lfe_ctrl.sv
design/lfe_dp.sv
design/lfe_lowpass_with_delay_unit.sv
test/lfe_lowpass_with_delay_unit_tb.sv
